/* rtl/core/dual_array_priority_run_queue_assert.svh */
// Assertion macros shared by the run queue checker.
// No dependencies; include this file by its bare name.
`ifndef DUAL_ARRAY_PRIORITY_RUN_QUEUE_ASSERT_SVH
`define DUAL_ARRAY_PRIORITY_RUN_QUEUE_ASSERT_SVH

// Checked only while reset is released.
`define DAPQ_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("run queue check failed");

// Checked in every cycle, reset included.
`define DAPQ_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("run queue reset check failed");

`endif

/* rtl/core/dapq_pkg.sv */
// Shared types and constants of the dual array priority run queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dapq_pkg;

    localparam int THREAD_SLOTS_DEF = 512;
    localparam int PRIO_LEVELS_DEF  = 8;

    localparam int TID_W    = 9;
    localparam int PRIO_W   = 8;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_WAKE    = 2'd0,
        OP_REQUEUE = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_PICK    = 2'd3
    } op_t;

endpackage
`default_nettype wire

/* rtl/core/dapq_link_ram.sv */
// Single write port, single registered read port link memory.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dapq_link_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 10
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] wa,
    input  wire logic [DW-1:0] wd,
    input  wire logic [AW-1:0] ra,
    output logic      [DW-1:0] rd
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd <= mem[ra];
    end

endmodule
`default_nettype wire

/* rtl/core/dual_array_priority_run_queue.sv */
// Top level of the dual array priority run queue scheduler.
// Depends on dapq_pkg and dapq_link_ram.
`timescale 1ns / 1ps
`default_nettype none
// Each request is handled by a small sequencer that drives one link memory port pair: a wake
// or requeue passes an update and a link state, a remove read, splice and clear states, and a
// pick scans priority levels (at most 2*PRIO_LEVELS) before read, pop and clear; each ends in
// ST_DONE, which presents the result. s_tready is low while a request is in progress. After
// reset the link memories are swept to null, one entry per cycle, before the first request.
module dual_array_priority_run_queue #(
    parameter int THREAD_SLOTS = dapq_pkg::THREAD_SLOTS_DEF,
    parameter int PRIO_LEVELS  = dapq_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // Bits from low: thread_id (9), priority_req (8), zero fill.
    input  wire logic [dapq_pkg::S_DATA_W-1:0] s_tdata,
    // Bits from low: operation (2).
    input  wire logic [1:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // Bits from low: picked_valid (1), picked_thread (9), sets_swapped (1), zero fill.
    output logic [dapq_pkg::M_DATA_W-1:0]      m_tdata
);
    import dapq_pkg::*;

    localparam int AW  = $clog2(THREAD_SLOTS);
    localparam int LW  = $clog2(THREAD_SLOTS + 1);
    localparam int LVW = $clog2(PRIO_LEVELS);
    localparam int QN  = 2 << LVW;
    localparam logic [LW-1:0]  NIL    = LW'(THREAD_SLOTS);
    localparam logic [LVW-1:0] LOWEST = LVW'(PRIO_LEVELS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_WAKE, ST_WAKE_LINK, ST_REQ, ST_REQ_LINK,
        ST_REM_RD, ST_REM_S0, ST_REM_S1, ST_REM_CLR,
        ST_SCAN, ST_POP_RD, ST_POP, ST_POP_CLR, ST_DONE
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   t_reg;
    logic [LVW-1:0]  lvl_reg;
    logic [LVW-1:0]  rl_reg;
    logic            act_reg;
    logic            swapped_reg;
    logic [LW-1:0]   h_reg;
    logic [LW-1:0]   nx_reg;
    logic [LW-1:0]   pv_reg;
    logic            res_valid_reg;
    logic [TID_W-1:0] res_thread_reg;
    logic            res_swap_reg;
    logic            m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [LW-1:0]   head_reg [QN];
    logic [LW-1:0]   tail_reg [QN];

    logic [TID_W-1:0]  in_tid;
    logic [PRIO_W-1:0] in_prio;
    logic [LVW-1:0]    in_lvl;
    logic              in_range;
    logic [LVW:0]      qidx;
    logic [LW-1:0]     head_cur;
    logic [LW-1:0]     tail_cur;
    logic [LW-1:0]     t_lw;
    logic              nwe, pwe;
    logic [AW-1:0]     nwa, pwa;
    logic [LW-1:0]     nwd, pwd;
    logic [LW-1:0]     nrd, prd;
    logic              accept;

    assign in_tid   = s_tdata[TID_W-1:0];
    assign in_prio  = s_tdata[TID_W+PRIO_W-1:TID_W];
    assign in_lvl   = (32'(in_prio) > PRIO_LEVELS - 1) ? LOWEST : LVW'(in_prio);
    assign in_range = 32'(in_tid) < 32'(THREAD_SLOTS);
    assign t_lw     = LW'(t_reg);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        case (state_reg)
            ST_WAKE, ST_REQ, ST_REM_S0: qidx = {~act_reg, lvl_reg};
            ST_REM_S1:                  qidx = {act_reg, lvl_reg};
            default:                    qidx = {act_reg, rl_reg};
        endcase
    end

    assign head_cur = head_reg[qidx];
    assign tail_cur = tail_reg[qidx];

    always_comb begin
        nwe = 1'b0;
        pwe = 1'b0;
        nwa = t_reg;
        pwa = t_reg;
        nwd = NIL;
        pwd = NIL;
        case (state_reg)
            ST_CLEAR: begin
                nwe = 1'b1;
                pwe = 1'b1;
                nwa = clr_reg;
                pwa = clr_reg;
            end
            ST_WAKE: begin
                nwe = 1'b1;
                nwd = head_cur;
                pwe = 1'b1;
            end
            ST_WAKE_LINK: begin
                pwe = (h_reg != NIL);
                pwa = AW'(h_reg);
                pwd = t_lw;
            end
            ST_REQ: begin
                nwe = 1'b1;
                pwe = 1'b1;
                pwd = tail_cur;
            end
            ST_REQ_LINK: begin
                nwe = (h_reg != NIL);
                nwa = AW'(h_reg);
                nwd = t_lw;
            end
            ST_REM_S1: begin
                nwe = (pv_reg != NIL);
                nwa = AW'(pv_reg);
                nwd = nx_reg;
                pwe = (nx_reg != NIL);
                pwa = AW'(nx_reg);
                pwd = pv_reg;
            end
            ST_REM_CLR: begin
                nwe = 1'b1;
                pwe = 1'b1;
            end
            ST_POP: begin
                nwe = 1'b1;
                pwe = (nrd != NIL);
                pwa = AW'(nrd);
            end
            ST_POP_CLR: begin
                pwe = 1'b1;
            end
            default: begin
            end
        endcase
    end

    dapq_link_ram #(.DEPTH(THREAD_SLOTS), .AW(AW), .DW(LW)) u_next_ram (
        .aclk(aclk), .we(nwe), .wa(nwa), .wd(nwd), .ra(t_reg), .rd(nrd)
    );

    dapq_link_ram #(.DEPTH(THREAD_SLOTS), .AW(AW), .DW(LW)) u_prev_ram (
        .aclk(aclk), .we(pwe), .wa(pwa), .wd(pwd), .ra(t_reg), .rd(prd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            act_reg      <= 1'b0;
            rl_reg       <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < QN; i++) begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end else begin
            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == THREAD_SLOTS - 1) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        t_reg          <= AW'(in_tid);
                        lvl_reg        <= in_lvl;
                        swapped_reg    <= 1'b0;
                        res_valid_reg  <= 1'b0;
                        res_thread_reg <= '0;
                        res_swap_reg   <= 1'b0;
                        if (op_t'(s_tuser) == OP_PICK) begin
                            state_reg <= ST_SCAN;
                        end else if (!in_range) begin
                            state_reg <= ST_DONE;
                        end else begin
                            case (op_t'(s_tuser))
                                OP_WAKE:    state_reg <= ST_WAKE;
                                OP_REQUEUE: state_reg <= ST_REQ;
                                default:    state_reg <= ST_REM_RD;
                            endcase
                        end
                    end
                end
                ST_WAKE: begin
                    h_reg          <= head_cur;
                    head_reg[qidx] <= t_lw;
                    if (head_cur == NIL) begin
                        tail_reg[qidx] <= t_lw;
                    end
                    state_reg <= ST_WAKE_LINK;
                end
                ST_REQ: begin
                    h_reg          <= tail_cur;
                    tail_reg[qidx] <= t_lw;
                    if (tail_cur == NIL) begin
                        head_reg[qidx] <= t_lw;
                    end
                    state_reg <= ST_REQ_LINK;
                end
                ST_WAKE_LINK, ST_REQ_LINK, ST_REM_CLR: begin
                    state_reg <= ST_DONE;
                end
                ST_REM_RD: begin
                    state_reg <= ST_REM_S0;
                end
                ST_REM_S0: begin
                    nx_reg <= nrd;
                    pv_reg <= prd;
                    if (tail_cur == t_lw) begin
                        tail_reg[qidx] <= prd;
                    end
                    if (head_cur == t_lw) begin
                        head_reg[qidx] <= nrd;
                    end
                    state_reg <= ST_REM_S1;
                end
                ST_REM_S1: begin
                    if (tail_cur == t_lw) begin
                        tail_reg[qidx] <= pv_reg;
                    end
                    if (head_cur == t_lw) begin
                        head_reg[qidx] <= nx_reg;
                    end
                    state_reg <= ST_REM_CLR;
                end
                ST_SCAN: begin
                    if (head_cur != NIL) begin
                        t_reg     <= AW'(head_cur);
                        state_reg <= ST_POP_RD;
                    end else if (rl_reg == LOWEST) begin
                        if (swapped_reg) begin
                            res_swap_reg <= 1'b1;
                            state_reg    <= ST_DONE;
                        end else begin
                            act_reg     <= ~act_reg;
                            rl_reg      <= '0;
                            swapped_reg <= 1'b1;
                        end
                    end else begin
                        rl_reg <= rl_reg + 1'b1;
                    end
                end
                ST_POP_RD: begin
                    state_reg <= ST_POP;
                end
                ST_POP: begin
                    head_reg[qidx] <= nrd;
                    if (tail_cur == t_lw) begin
                        tail_reg[qidx] <= NIL;
                    end
                    state_reg <= ST_POP_CLR;
                end
                ST_POP_CLR: begin
                    res_valid_reg  <= 1'b1;
                    res_thread_reg <= TID_W'(t_reg);
                    res_swap_reg   <= swapped_reg;
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_DATA_W'({res_swap_reg, res_thread_reg,
                                                   res_valid_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/dapq_checker.sv */
// Port level checker of the run queue, bound to the top level.
// Depends on dapq_pkg and dual_array_priority_run_queue_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_array_priority_run_queue_assert.svh"
module dapq_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [1:0]                    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dapq_pkg::M_DATA_W-1:0] m_tdata
);
    import dapq_pkg::*;

    // A stalled result holds.
    `DAPQ_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    // A request keeps the block busy after it is accepted.
    `DAPQ_ASSERT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    // A result without a thread carries thread zero, and fill bits stay zero.
    `DAPQ_ASSERT(a_no_thread_zero, aclk, aresetn, m_tvalid && !m_tdata[0] |-> m_tdata[9:1] == 9'd0)
    `DAPQ_ASSERT(a_fill_zero, aclk, aresetn, m_tvalid |-> m_tdata[M_DATA_W-1:11] == '0)
    // Reset leaves no result pending.
    `DAPQ_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)

endmodule

bind dual_array_priority_run_queue dapq_checker u_dapq_checker (.*);
`default_nettype wire
